/* rtl/hrb_pkg.sv */
// Shared types and command codes for the history ring buffer.
package hrb_pkg;

    localparam logic [2:0] OP_PUSH        = 3'd0;
    localparam logic [2:0] OP_PUSH_UNIQUE = 3'd1;
    localparam logic [2:0] OP_STEP_OLDER  = 3'd2;
    localparam logic [2:0] OP_STEP_NEWER  = 3'd3;
    localparam logic [2:0] OP_RESET_CUR   = 3'd4;
    localparam logic [2:0] OP_CONTAINS    = 3'd5;

    localparam int RESULT_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SEARCH,
        ST_SHIFT,
        ST_RESP
    } hrb_state_t;

    typedef struct packed {
        logic done;
        logic valid;
        logic present;
    } hrb_resp_t;

endpackage

/* rtl/history_ring_buffer_top.sv */
// History ring buffer with browse cursor and move-to-front unique push.
// Sequence: push, step and reset cursor pass through the execute and response states;
// contains and unique push add a scan of the filled slots (one compare per cycle),
// and a unique push hit adds a gap-closing shift through the store's ports.
// Throughput: one word at a time; a new start is taken in the cycle after done.
// Reset: rst_n clears the ring to empty with the cursor parked; store contents are not cleared.
module history_ring_buffer_top #(
    parameter int DEPTH       = 16,
    parameter int ENTRY_WIDTH = 32,
    localparam int AW         = $clog2(DEPTH),
    localparam int CW         = $clog2(DEPTH + 1),
    localparam int SW         = (ENTRY_WIDTH < hrb_pkg::RESULT_W) ? ENTRY_WIDTH
                                                                  : hrb_pkg::RESULT_W
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  logic [2:0]    op,
    input  logic [31:0]   entry_value,
    output logic          done,
    output logic [31:0]   read_value,
    output logic          read_valid,
    output logic [CW-1:0] cursor_count,
    output logic          is_present
);

    hrb_pkg::hrb_resp_t resp;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [SW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [SW-1:0] mem_rdata;

    hrb_ctrl #(
        .DEPTH  (DEPTH),
        .DATA_W (SW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .op          (op),
        .value       (entry_value[SW-1:0]),
        .busy        (busy),
        .resp        (resp),
        .older_count (cursor_count),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    hrb_mem #(
        .DEPTH  (DEPTH),
        .DATA_W (SW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign done       = resp.done;
    assign read_valid = resp.done && resp.valid;
    assign is_present = resp.done && resp.present;
    assign read_value = read_valid ? 32'(mem_rdata) : '0;

endmodule

/* rtl/hrb_mem.sv */
// Entry store: one write port, one read port with registered read data.
module hrb_mem #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/hrb_ctrl.sv */
// Sequencer: ring pointers, cursor, sequential search and gap-closing shift.
module hrb_ctrl #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 32,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        op,
    input  logic [DATA_W-1:0] value,
    output logic              busy,
    output hrb_pkg::hrb_resp_t resp,
    output logic [CW-1:0]     older_count,
    output logic              mem_we,
    output logic [AW-1:0]     mem_waddr,
    output logic [DATA_W-1:0] mem_wdata,
    output logic              mem_re,
    output logic [AW-1:0]     mem_raddr,
    input  logic [DATA_W-1:0] mem_rdata
);

    hrb_pkg::hrb_state_t state_reg, state_next;
    logic [2:0]        op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     wpos_reg, wpos_next;
    logic [AW-1:0]     cpos_reg, cpos_next;
    logic [CW-1:0]     older_reg, older_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     rdp_reg, rdp_next;
    logic [AW-1:0]     wrp_reg, wrp_next;
    logic [AW-1:0]     rem_reg, rem_next;
    logic              down_reg, down_next;
    logic              ok_reg, ok_next;
    logic              present_reg, present_next;

    logic              do_push;
    logic              not_full;
    logic              issue;
    logic              match;
    logic [AW-1:0]     hit;
    logic [CW-1:0]     fill_dec;
    logic [CW-1:0]     scan_dec;
    logic [AW-1:0]     cpos_step;

    function automatic logic [AW-1:0] adv(input logic [AW-1:0] pos);
        logic [AW-1:0] r;
        if (pos == AW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = pos + 1'b1;
        end
        return r;
    endfunction

    assign not_full = (fill_reg < CW'(DEPTH));
    assign fill_dec = fill_reg - 1'b1;
    assign scan_dec = scan_reg - 1'b1;
    assign hit      = scan_dec[AW-1:0];
    assign match    = pend_reg && (mem_rdata == val_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hrb_pkg::ST_IDLE;
            op_reg      <= '0;
            fill_reg    <= '0;
            wpos_reg    <= '0;
            cpos_reg    <= '0;
            older_reg   <= '0;
            scan_reg    <= '0;
            pend_reg    <= 1'b0;
            rem_reg     <= '0;
            down_reg    <= 1'b0;
            ok_reg      <= 1'b0;
            present_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            fill_reg    <= fill_next;
            wpos_reg    <= wpos_next;
            cpos_reg    <= cpos_next;
            older_reg   <= older_next;
            scan_reg    <= scan_next;
            pend_reg    <= pend_next;
            rem_reg     <= rem_next;
            down_reg    <= down_next;
            ok_reg      <= ok_next;
            present_reg <= present_next;
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
        rdp_reg <= rdp_next;
        wrp_reg <= wrp_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        val_next     = val_reg;
        fill_next    = fill_reg;
        wpos_next    = wpos_reg;
        cpos_next    = cpos_reg;
        older_next   = older_reg;
        scan_next    = scan_reg;
        pend_next    = pend_reg;
        rdp_next     = rdp_reg;
        wrp_next     = wrp_reg;
        rem_next     = rem_reg;
        down_next    = down_reg;
        ok_next      = ok_reg;
        present_next = present_reg;
        do_push      = 1'b0;
        issue        = 1'b0;
        cpos_step    = cpos_reg;
        mem_we       = 1'b0;
        mem_waddr    = wpos_reg;
        mem_wdata    = val_reg;
        mem_re       = 1'b0;
        mem_raddr    = scan_reg[AW-1:0];

        unique case (state_reg)
            hrb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    op_next      = op;
                    val_next     = value;
                    ok_next      = 1'b0;
                    present_next = 1'b0;
                    scan_next    = '0;
                    pend_next    = 1'b0;
                    state_next   = hrb_pkg::ST_EXEC;
                end
            end

            hrb_pkg::ST_EXEC:
            begin
                state_next = hrb_pkg::ST_RESP;
                unique case (op_reg) inside
                    hrb_pkg::OP_PUSH:
                    begin
                        do_push = 1'b1;
                    end
                    hrb_pkg::OP_PUSH_UNIQUE, hrb_pkg::OP_CONTAINS:
                    begin
                        state_next = hrb_pkg::ST_SEARCH;
                    end
                    hrb_pkg::OP_STEP_OLDER:
                    begin
                        if (older_reg != '0)
                        begin
                            // wrap to the highest filled slot
                            cpos_step  = (cpos_reg == '0) ? fill_dec[AW-1:0]
                                                           : cpos_reg - 1'b1;
                            cpos_next  = cpos_step;
                            older_next = older_reg - 1'b1;
                            mem_re     = 1'b1;
                            mem_raddr  = cpos_step;
                            ok_next    = 1'b1;
                        end
                    end
                    hrb_pkg::OP_STEP_NEWER:
                    begin
                        if (({1'b0, older_reg} + 1'b1) < {1'b0, fill_reg})
                        begin
                            cpos_step  = adv(cpos_reg);
                            cpos_next  = cpos_step;
                            older_next = older_reg + 1'b1;
                            mem_re     = 1'b1;
                            mem_raddr  = cpos_step;
                            ok_next    = 1'b1;
                        end
                    end
                    hrb_pkg::OP_RESET_CUR:
                    begin
                        cpos_next  = wpos_reg;
                        older_next = fill_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end

            hrb_pkg::ST_SEARCH:
            begin
                // read slot scan, compare it in the next cycle
                issue     = (scan_reg < fill_reg);
                mem_re    = issue;
                mem_raddr = scan_reg[AW-1:0];
                if (match)
                begin
                    if (op_reg == hrb_pkg::OP_CONTAINS)
                    begin
                        present_next = 1'b1;
                        state_next   = hrb_pkg::ST_RESP;
                    end
                    else if (hit == wpos_reg)
                    begin
                        do_push    = 1'b1;
                        state_next = hrb_pkg::ST_RESP;
                    end
                    else if (hit < wpos_reg)
                    begin
                        down_next  = 1'b0;
                        rdp_next   = hit + 1'b1;
                        wrp_next   = hit;
                        rem_next   = wpos_reg - hit - 1'b1;
                        pend_next  = 1'b0;
                        state_next = hrb_pkg::ST_SHIFT;
                    end
                    else
                    begin
                        down_next  = 1'b1;
                        rdp_next   = hit - 1'b1;
                        wrp_next   = hit;
                        rem_next   = hit - wpos_reg;
                        pend_next  = 1'b0;
                        state_next = hrb_pkg::ST_SHIFT;
                    end
                end
                else if (!issue)
                begin
                    do_push    = (op_reg == hrb_pkg::OP_PUSH_UNIQUE);
                    state_next = hrb_pkg::ST_RESP;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end

            hrb_pkg::ST_SHIFT:
            begin
                // read neighbor ahead, write it back one slot behind
                issue     = (rem_reg != '0);
                mem_re    = issue;
                mem_raddr = rdp_reg;
                pend_next = issue;
                if (issue)
                begin
                    rdp_next = down_reg ? rdp_reg - 1'b1 : rdp_reg + 1'b1;
                    rem_next = rem_reg - 1'b1;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wrp_reg;
                    mem_wdata = mem_rdata;
                    wrp_next  = down_reg ? wrp_reg - 1'b1 : wrp_reg + 1'b1;
                end
                else if (!issue)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = wrp_reg;
                    mem_wdata  = val_reg;
                    cpos_next  = down_reg ? adv(wpos_reg) : wpos_reg;
                    wpos_next  = down_reg ? adv(wpos_reg) : wpos_reg;
                    older_next = fill_reg;
                    state_next = hrb_pkg::ST_RESP;
                end
            end

            hrb_pkg::ST_RESP:
            begin
                state_next = hrb_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = hrb_pkg::ST_IDLE;
            end
        endcase

        if (do_push)
        begin
            mem_we     = 1'b1;
            mem_waddr  = wpos_reg;
            mem_wdata  = val_reg;
            fill_next  = not_full ? fill_reg + 1'b1 : fill_reg;
            wpos_next  = adv(wpos_reg);
            cpos_next  = adv(wpos_reg);
            older_next = not_full ? fill_reg + 1'b1 : fill_reg;
        end
    end

    assign busy         = (state_reg != hrb_pkg::ST_IDLE);
    assign resp.done    = (state_reg == hrb_pkg::ST_RESP);
    assign resp.valid   = ok_reg;
    assign resp.present = present_reg;
    assign older_count  = older_reg;

endmodule

/* rtl/history_ring_buffer_checker.sv */
// Port-level checks for the history ring buffer, bound to the top level.
module history_ring_buffer_checker #(
    parameter int DEPTH = 16,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input logic          read_valid,
    input logic          is_present,
    input logic [CW-1:0] cursor_count
);

    // a result only ends an accepted word
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without a word in flight");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // accepted word never completes in the next cycle
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word not held busy");

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(read_valid && is_present))
        else $error("step data and presence flagged together");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cursor_count <= CW'(DEPTH)))
        else $error("cursor count beyond ring depth");

endmodule

bind history_ring_buffer_top history_ring_buffer_checker #(
    .DEPTH (DEPTH)
) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .read_valid   (read_valid),
    .is_present   (is_present),
    .cursor_count (cursor_count)
);

/* tb/testbench.sv */
// Self-checking testbench for history_ring_buffer_top.
`timescale 1ns / 100ps

module testbench;

    localparam int HIST_DEPTH = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 48;
    // op codes with no function; the block must leave its state alone
    localparam logic [2:0] OP_RSVD_LO = 3'd6;
    localparam logic [2:0] OP_RSVD_HI = 3'd7;

    typedef struct packed {
        logic [31:0] value;
        logic        valid;
        logic [4:0]  count;
        logic        present;
    } hist_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [2:0]  op = hrb_pkg::OP_PUSH;
    logic [31:0] entry_value = '0;
    logic        busy;
    logic        done;
    logic [31:0] read_value;
    logic        read_valid;
    logic [4:0]  cursor_count;
    logic        is_present;

    history_ring_buffer_top #(
        .DEPTH(HIST_DEPTH),
        .ENTRY_WIDTH(32)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .entry_value(entry_value),
        .done(done),
        .read_value(read_value),
        .read_valid(read_valid),
        .cursor_count(cursor_count),
        .is_present(is_present)
    );

    // shadow copy of the ring
    logic [31:0] hist_mem [HIST_DEPTH];
    int hist_fill = 0;
    int hist_wr = 0;
    int hist_cur = 0;
    int hist_older = 0;

    hist_result_t pending_results[$];
    int err_count = 0;
    int words_sent = 0;
    int results_seen = 0;
    int valid_steps = 0;
    int present_hits = 0;
    int unique_moves = 0;
    int idle_pct = 0;
    int quiet_cycles = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    // lowest slot holding v, or -1
    function automatic int find_slot(logic [31:0] v);
        for (int i = 0; i < hist_fill; i++)
        begin
            if (hist_mem[i] == v)
                return i;
        end
        return -1;
    endfunction

    task automatic hist_push(input logic [31:0] v);
        if (hist_fill < HIST_DEPTH)
        begin
            hist_mem[hist_fill] = v;
            hist_fill++;
        end
        else
            hist_mem[hist_wr] = v;
        hist_wr = (hist_wr + 1) % HIST_DEPTH;
        hist_cur = hist_wr;
        hist_older = hist_fill;
    endtask

    task automatic predict_word(input logic [2:0] cmd, input logic [31:0] v,
                                output hist_result_t r);
        int hit;
        int w;
        r = '0;
        case (cmd)
            hrb_pkg::OP_PUSH:
                hist_push(v);
            hrb_pkg::OP_PUSH_UNIQUE:
            begin
                hit = find_slot(v);
                w = hist_wr;
                // a hit on the oldest entry of a full ring is just an overwrite
                if (hit < 0 || hit == w)
                    hist_push(v);
                else
                begin
                    unique_moves++;
                    if (hit < w)
                    begin
                        for (int k = hit; k + 1 < w; k++)
                            hist_mem[k] = hist_mem[k + 1];
                        hist_mem[w - 1] = v;
                    end
                    else
                    begin
                        for (int k = hit; k > w; k--)
                            hist_mem[k] = hist_mem[k - 1];
                        hist_mem[w] = v;
                        hist_wr = (w + 1) % HIST_DEPTH;
                    end
                    hist_cur = hist_wr;
                    hist_older = hist_fill;
                end
            end
            hrb_pkg::OP_STEP_OLDER:
            begin
                if (hist_older != 0)
                begin
                    hist_cur = (hist_cur == 0) ? hist_fill - 1 : hist_cur - 1;
                    hist_older--;
                    r.value = hist_mem[hist_cur];
                    r.valid = 1'b1;
                end
            end
            hrb_pkg::OP_STEP_NEWER:
            begin
                // cannot step back onto the parked slot
                if (hist_older + 1 < hist_fill)
                begin
                    hist_cur = (hist_cur + 1) % HIST_DEPTH;
                    hist_older++;
                    r.value = hist_mem[hist_cur];
                    r.valid = 1'b1;
                end
            end
            hrb_pkg::OP_RESET_CUR:
            begin
                hist_cur = hist_wr;
                hist_older = hist_fill;
            end
            hrb_pkg::OP_CONTAINS:
                r.present = (find_slot(v) >= 0);
            default:
                ;
        endcase
        r.count = 5'(hist_older);
        if (r.valid)
            valid_steps++;
        if (r.present)
            present_hits++;
    endtask

    // present one word, wait for it to be taken, then maybe pause
    task automatic send_word(input logic [2:0] cmd, input logic [31:0] v);
        hist_result_t r;
        int gap;
        start <= 1'b1;
        op <= cmd;
        entry_value <= v;
        do @(posedge clk); while (busy);
        predict_word(cmd, v, r);
        pending_results.push_back(r);
        words_sent++;
        if ($urandom_range(0, 99) < idle_pct)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // small pool so that unique pushes and lookups hit often
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9)) inside
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2, 3: return 32'(($urandom_range(0, 5) << 4) | 32'h1);
            4: return 32'hA5A5_0000 | 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_empty_ring();
        send_word(hrb_pkg::OP_STEP_OLDER, 32'h0);
        send_word(hrb_pkg::OP_STEP_NEWER, 32'h0);
        send_word(hrb_pkg::OP_CONTAINS, 32'h0);
        send_word(hrb_pkg::OP_CONTAINS, 32'hFFFF_FFFF);
        send_word(hrb_pkg::OP_PUSH_UNIQUE, 32'h0);
        send_word(hrb_pkg::OP_RESET_CUR, 32'h0);
        send_word(OP_RSVD_LO, 32'hFFFF_FFFF);
        send_word(OP_RSVD_HI, 32'h5A5A_5A5A);
    endtask

    task automatic test_push_browse();
        send_word(hrb_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_word(hrb_pkg::OP_PUSH, 32'h0);
        send_word(hrb_pkg::OP_PUSH, 32'hFFFF_FFFF);
        // duplicate: lowest matching slot moves to newest
        send_word(hrb_pkg::OP_PUSH_UNIQUE, 32'hFFFF_FFFF);
        send_word(hrb_pkg::OP_CONTAINS, 32'h0);
        repeat (5) send_word(hrb_pkg::OP_STEP_OLDER, 32'h0);
        repeat (4) send_word(hrb_pkg::OP_STEP_NEWER, 32'h0);
        send_word(hrb_pkg::OP_RESET_CUR, 32'h0);
        send_word(hrb_pkg::OP_STEP_OLDER, 32'h0);
    endtask

    task automatic test_wrap();
        for (int i = 0; i < HIST_DEPTH; i++)
            send_word(hrb_pkg::OP_PUSH, 32'h100 + i);
        // oldest entry sits at the write slot now
        send_word(hrb_pkg::OP_PUSH_UNIQUE, 32'h102);
        // hit above the write slot, then on it
        send_word(hrb_pkg::OP_PUSH_UNIQUE, 32'h108);
        send_word(hrb_pkg::OP_PUSH_UNIQUE, 32'h100);
        send_word(hrb_pkg::OP_STEP_OLDER, 32'h0);
        send_word(hrb_pkg::OP_CONTAINS, 32'h10F);
    endtask

    task automatic test_random(input int n_words);
        int sent;
        int olders;
        int newers;
        int choice;
        logic [2:0] cmd;
        sent = 0;
        while (sent < n_words)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                // browse run: walk back, sometimes past the end, then forward
                olders = $urandom_range(1, HIST_DEPTH + 2);
                newers = $urandom_range(0, olders + 1);
                repeat (olders) send_word(hrb_pkg::OP_STEP_OLDER, $urandom);
                repeat (newers) send_word(hrb_pkg::OP_STEP_NEWER, $urandom);
                sent += olders + newers;
            end
            else
            begin
                choice = $urandom_range(0, 99);
                if (choice < 28)
                    cmd = hrb_pkg::OP_PUSH;
                else if (choice < 58)
                    cmd = hrb_pkg::OP_PUSH_UNIQUE;
                else if (choice < 68)
                    cmd = hrb_pkg::OP_STEP_OLDER;
                else if (choice < 77)
                    cmd = hrb_pkg::OP_STEP_NEWER;
                else if (choice < 84)
                    cmd = hrb_pkg::OP_RESET_CUR;
                else if (choice < 96)
                    cmd = hrb_pkg::OP_CONTAINS;
                else
                    cmd = $urandom_range(0, 1) ? OP_RSVD_LO : OP_RSVD_HI;
                send_word(cmd, pick_value());
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        hist_result_t want;
        hist_result_t got;
        if (rst_n && done)
        begin
            got = '{read_value, read_valid, cursor_count, is_present};
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected word: value=%h valid=%b count=%0d present=%b",
                         $time, got.value, got.valid, got.count, got.present);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    $display("%0t: mismatch: expected value=%h valid=%b count=%0d present=%b",
                             $time, want.value, want.valid, want.count, want.present);
                    $display("%0t:           actual value=%h valid=%b count=%0d present=%b",
                             $time, got.value, got.valid, got.count, got.present);
                    err_count++;
                end
            end
        end
    end

    // watchdog: cycles with neither a word taken nor a result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 21;
        test_empty_ring();
        test_push_browse();
        test_wrap();
        test_random(150);
        idle_pct = 64;
        test_random(150);
        idle_pct = 0;
        test_random(150);
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d words and %0d results: %0d valid steps, %0d lookup hits,",
                 words_sent, results_seen, valid_steps, present_hits);
        $display("%0d move-to-front pushes; %0d mismatches", unique_moves, err_count);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
